FILE: rtl/touch_affine_map_assert.svh
// touch_affine_map_assert.svh: assertion macros for the touch map rtl
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef TOUCH_AFFINE_MAP_ASSERT_SVH
`define TOUCH_AFFINE_MAP_ASSERT_SVH

// same-cycle implication, checked at every rising edge out of reset
`define TAM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TAM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tam_pkg.sv
// tam_pkg.sv: widths, register indexes and types of the touch affine map
// no dependencies; used by tam_axis_finish and touch_affine_map
`timescale 1ns / 1ps
`default_nettype none

package tam_pkg;

    localparam int RAW_W      = 16;
    localparam int LIM_W      = 15;
    localparam int GAIN_W     = 24;
    localparam int OFFS_W     = 31;
    localparam int ORIENT_W   = 3;
    localparam int OUT_W      = 16;
    localparam int FRAC_W     = 16;
    localparam int COORD_W    = RAW_W + 1;          // holds +32768 after negation
    localparam int PROD_W     = COORD_W + GAIN_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = OFFS_W;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 40;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_XX     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_XY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_YX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_YY     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION = 3'd6;

    // orientation register bits
    localparam int ORIENT_SWAP  = 0;
    localparam int ORIENT_NEG_X = 1;
    localparam int ORIENT_NEG_Y = 2;

    // reset values
    localparam logic signed [GAIN_W-1:0] GAIN_ONE = 24'sd65536;

    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [OUT_W-1:0]  screen_t;
    typedef logic        [LIM_W-1:0]  limit_t;

endpackage

`default_nettype wire

FILE: rtl/tam_axis_finish.sv
// tam_axis_finish.sv: clamp, round half to even and saturate one axis
// depends on tam_pkg
`timescale 1ns / 1ps
`default_nettype none

module tam_axis_finish (
    input  var tam_pkg::acc_t    acc,
    input  var tam_pkg::limit_t  limit,
    output tam_pkg::screen_t     value,
    output logic                 sat
);

    localparam int QW = tam_pkg::ACC_W - tam_pkg::FRAC_W;
    localparam int RW = QW + 1;
    localparam logic signed [RW-1:0] R_MAX = RW'(2 ** (tam_pkg::OUT_W - 1) - 1);
    localparam logic signed [RW-1:0] R_MIN = -R_MAX - RW'(1);

    tam_pkg::limit_t              lim_m1;
    tam_pkg::acc_t                top;
    tam_pkg::acc_t                acc_c;
    logic signed [QW-1:0]         q;
    logic [tam_pkg::FRAC_W-1:0]   frac;
    logic                         inc;
    logic signed [RW-1:0]         r;

    assign lim_m1 = limit - tam_pkg::LIM_W'(1);
    assign top    = $signed({{(tam_pkg::ACC_W - tam_pkg::LIM_W - tam_pkg::FRAC_W){1'b0}},
                             lim_m1, {tam_pkg::FRAC_W{1'b0}}});

    // clamp to [0, limit-1] in q.16 when a limit is given
    always_comb
    begin
        acc_c = acc;
        if (limit != '0)
        begin
            priority if (acc < 0)
                acc_c = '0;
            else if (acc > top)
                acc_c = top;
        end
    end

    // floor then bump for above half, or exactly half on an odd value
    assign q    = acc_c[tam_pkg::ACC_W-1:tam_pkg::FRAC_W];
    assign frac = acc_c[tam_pkg::FRAC_W-1:0];
    assign inc  = frac[tam_pkg::FRAC_W-1] && ((frac[tam_pkg::FRAC_W-2:0] != '0) || q[0]);
    assign r    = $signed({q[QW-1], q} + {{(RW-1){1'b0}}, inc});

    always_comb
    begin
        priority if (r > R_MAX)
        begin
            value = R_MAX[tam_pkg::OUT_W-1:0];
            sat   = 1'b1;
        end
        else if (r < R_MIN)
        begin
            value = R_MIN[tam_pkg::OUT_W-1:0];
            sat   = 1'b1;
        end
        else
        begin
            value = r[tam_pkg::OUT_W-1:0];
            sat   = 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/touch_affine_map.sv
// touch_affine_map.sv: top level of the touch point calibration transform
// depends on tam_pkg, tam_axis_finish and touch_affine_map_assert.svh
`timescale 1ns / 1ps
`default_nettype none

// Maps one raw touch point to screen coordinates. Each word on the input stream
// goes through an optional swap/mirror (when orient_enable is set), a 2x3 affine
// matrix with signed Q7.16 gains and Q14.16 offsets, a clamp to [0, limit-1] on
// each axis with a nonzero limit, and round to nearest with ties to even. An axis
// with no limit saturates to 16-bit signed and raises status. The block is a
// three-stage pipeline (multiply, sum, finish) behind the input handshake; a new
// point is accepted every cycle unless the output stalls. Each stage moves on
// when it is empty or its successor takes its word, so bubbles are squeezed out
// while a result waits on the output. The matrix and orientation are written
// over the config port, which is always ready; write it only while no point is
// in flight.

module touch_affine_map (
    input  wire                             clk,
    input  wire                             rst_n,
    // config write channel
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire [tam_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [tam_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input stream
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // raw_x[15:0], raw_y[31:16], limit_x[46:32], limit_y[61:47],
    // orient_enable[62], zero pad[63]
    input  wire [tam_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // output stream
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // screen_x[15:0], screen_y[31:16], status[32], zero pad[39:33]
    output logic [tam_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    // config registers
    logic signed [tam_pkg::GAIN_W-1:0]  gain_xx_reg, gain_xy_reg, gain_yx_reg, gain_yy_reg;
    logic signed [tam_pkg::OFFS_W-1:0]  offset_x_reg, offset_y_reg;
    logic [tam_pkg::ORIENT_W-1:0]       orientation_reg;

    // input word fields
    logic signed [tam_pkg::RAW_W-1:0]   raw_x, raw_y;
    tam_pkg::limit_t                    limit_x, limit_y;
    logic                               orient_enable;

    // stage 1: products
    logic                               v1_reg;
    tam_pkg::prod_t                     p_xx_reg, p_xy_reg, p_yx_reg, p_yy_reg;
    tam_pkg::limit_t                    lim_x1_reg, lim_y1_reg;

    // stage 2: sums
    logic                               v2_reg;
    tam_pkg::acc_t                      acc_x_reg, acc_y_reg;
    tam_pkg::limit_t                    lim_x2_reg, lim_y2_reg;

    // stage 3: result
    logic                               v3_reg;
    tam_pkg::screen_t                   screen_x_reg, screen_y_reg;
    logic                               status_reg;

    logic                               ld1, ld2, ld3;
    logic signed [tam_pkg::COORD_W-1:0] x_in, y_in, x_sw, y_sw, x_or, y_or;
    tam_pkg::acc_t                      acc_x_next, acc_y_next;
    tam_pkg::screen_t                   fin_x, fin_y;
    logic                               sat_x, sat_y;

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_xx_reg     <= tam_pkg::GAIN_ONE;
            gain_xy_reg     <= '0;
            offset_x_reg    <= '0;
            gain_yx_reg     <= '0;
            gain_yy_reg     <= tam_pkg::GAIN_ONE;
            offset_y_reg    <= '0;
            orientation_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tam_pkg::REG_GAIN_XX:     gain_xx_reg     <= cfg_data[tam_pkg::GAIN_W-1:0];
                tam_pkg::REG_GAIN_XY:     gain_xy_reg     <= cfg_data[tam_pkg::GAIN_W-1:0];
                tam_pkg::REG_OFFSET_X:    offset_x_reg    <= cfg_data[tam_pkg::OFFS_W-1:0];
                tam_pkg::REG_GAIN_YX:     gain_yx_reg     <= cfg_data[tam_pkg::GAIN_W-1:0];
                tam_pkg::REG_GAIN_YY:     gain_yy_reg     <= cfg_data[tam_pkg::GAIN_W-1:0];
                tam_pkg::REG_OFFSET_Y:    offset_y_reg    <= cfg_data[tam_pkg::OFFS_W-1:0];
                tam_pkg::REG_ORIENTATION: orientation_reg <= cfg_data[tam_pkg::ORIENT_W-1:0];
                default:                  ;  // index beyond the list: ignored
            endcase
        end
    end

    // ------------------------------------------------------- stage handshake
    // a stage loads when it is empty or its word moves on this cycle
    assign ld3           = !v3_reg || m_axis_tready;
    assign ld2           = !v2_reg || ld3;
    assign ld1           = !v1_reg || ld2;
    assign s_axis_tready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
                v1_reg <= s_axis_tvalid;
            if (ld2)
                v2_reg <= v1_reg;
            if (ld3)
                v3_reg <= v2_reg;
        end
    end

    // ------------------------------------------ stage 1: orientation, multiply
    assign raw_x         = s_axis_tdata[15:0];
    assign raw_y         = s_axis_tdata[31:16];
    assign limit_x       = s_axis_tdata[46:32];
    assign limit_y       = s_axis_tdata[61:47];
    assign orient_enable = s_axis_tdata[62];

    assign x_in = tam_pkg::COORD_W'(raw_x);
    assign y_in = tam_pkg::COORD_W'(raw_y);

    // swap first, then mirror; 17 bits keep -(-32768) exact
    always_comb
    begin
        x_sw = x_in;
        y_sw = y_in;
        if (orient_enable && orientation_reg[tam_pkg::ORIENT_SWAP])
        begin
            x_sw = y_in;
            y_sw = x_in;
        end
        x_or = (orient_enable && orientation_reg[tam_pkg::ORIENT_NEG_X]) ? -x_sw : x_sw;
        y_or = (orient_enable && orientation_reg[tam_pkg::ORIENT_NEG_Y]) ? -y_sw : y_sw;
    end

    always_ff @(posedge clk)
    begin
        if (ld1 && s_axis_tvalid)
        begin
            p_xx_reg   <= gain_xx_reg * x_or;
            p_xy_reg   <= gain_xy_reg * y_or;
            p_yx_reg   <= gain_yx_reg * x_or;
            p_yy_reg   <= gain_yy_reg * y_or;
            lim_x1_reg <= limit_x;
            lim_y1_reg <= limit_y;
        end
    end

    // ------------------------------------------------------- stage 2: sums
    assign acc_x_next = tam_pkg::ACC_W'(p_xx_reg) + tam_pkg::ACC_W'(p_xy_reg)
                      + tam_pkg::ACC_W'(offset_x_reg);
    assign acc_y_next = tam_pkg::ACC_W'(p_yx_reg) + tam_pkg::ACC_W'(p_yy_reg)
                      + tam_pkg::ACC_W'(offset_y_reg);

    always_ff @(posedge clk)
    begin
        if (ld2 && v1_reg)
        begin
            acc_x_reg  <= acc_x_next;
            acc_y_reg  <= acc_y_next;
            lim_x2_reg <= lim_x1_reg;
            lim_y2_reg <= lim_y1_reg;
        end
    end

    // ------------------------------------- stage 3: clamp, round, saturate
    tam_axis_finish u_finish_x (
        .acc   (acc_x_reg),
        .limit (lim_x2_reg),
        .value (fin_x),
        .sat   (sat_x)
    );

    tam_axis_finish u_finish_y (
        .acc   (acc_y_reg),
        .limit (lim_y2_reg),
        .value (fin_y),
        .sat   (sat_y)
    );

    always_ff @(posedge clk)
    begin
        if (ld3 && v2_reg)
        begin
            screen_x_reg <= fin_x;
            screen_y_reg <= fin_y;
            status_reg   <= sat_x || sat_y;
        end
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = {{(tam_pkg::M_TDATA_W - 2 * tam_pkg::OUT_W - 1){1'b0}},
                            status_reg, screen_y_reg, screen_x_reg};

    // ------------------------------------------------------------ checks
    `include "touch_affine_map_assert.svh"

    // an empty output register lets every stage load
    `TAM_ASSERT_NOW(a_ready_when_out_empty, !m_axis_tvalid, s_axis_tready,
        "input stalled with an empty output register")
    // an accepted word always lands in the first stage
    `TAM_ASSERT_NEXT(a_accept_fills_s1, s_axis_tvalid && s_axis_tready, v1_reg,
        "accepted word lost before the multiply stage")
    // a clamped x axis never saturates
    `TAM_ASSERT_NOW(a_clamp_no_sat, v2_reg && (lim_x2_reg != '0), !sat_x,
        "clamped x axis saturated")
    // status only with an axis pinned at a 16-bit bound
    `TAM_ASSERT_NOW(a_status_at_bound, m_axis_tvalid && status_reg,
        (screen_x_reg == 16'sh7fff) || (screen_x_reg == -16'sh8000) ||
        (screen_y_reg == 16'sh7fff) || (screen_y_reg == -16'sh8000),
        "status set without a saturated axis")

endmodule

`default_nettype wire
